[design/ifbr_pkg.sv]
// Package for the interlaced field bilinear resizer.
// Holds field widths, register indexes, opcodes and image geometry; no dependencies.
`default_nettype none
package ifbr_pkg;
   localparam int MAX_HEIGHT = 256;
   localparam int MAX_WIDTH  = 256;
   localparam int PLANES     = 3;
   localparam int FRAC_BITS  = 16;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 25;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_STEP     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_X_STEP     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERLACE  = 3'd4;

   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_REQUEST = 1'b1;

   // four banks: row bit 1 and column bit 0 select the bank
   localparam int BANK_DEPTH = PLANES * MAX_HEIGHT * MAX_WIDTH / 4;
   localparam int BANK_AW    = 16;
endpackage
`default_nettype wire

[design/ifbr_if.sv]
// Channel interfaces of the interlaced field bilinear resizer.
// Depends on ifbr_pkg for the configuration port widths.
`default_nettype none
interface ifbr_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [1:0] plane;
   logic [9:0] row;
   logic [9:0] col;
   logic [7:0] pixel_in;
   modport source (output valid, opcode, plane, row, col, pixel_in, input ready);
   modport sink (input valid, opcode, plane, row, col, pixel_in, output ready);
endinterface

interface ifbr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_pixel;
   logic       error;
   modport source (output valid, out_pixel, error, input ready);
   modport sink (input valid, out_pixel, error, output ready);
endinterface

interface ifbr_csr_if;
   logic                           valid;
   logic                           ready;
   logic [ifbr_pkg::CSR_IDX_W-1:0]  index;
   logic [ifbr_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[design/interlaced_field_bilinear_resize.sv]
// Throughput: one item per cycle;
// a stalled result holds the whole pipeline (multiply, bank read, two blend stages).
// Four image banks, split on row bit 1 and column bit 0, serve all four taps at once.
// Reset restores the registers to their defaults; image memory is not cleared.
// Depends on ifbr_pkg and ifbr_if.
`default_nettype none
module interlaced_field_bilinear_resize (
   input wire clock,
   input wire reset,
   ifbr_req_if.sink   req_ch,
   ifbr_rsp_if.source rsp_ch,
   ifbr_csr_if.sink   csr_ch
);
   import ifbr_pkg::*;

   localparam logic [16:0] ONE = 17'h10000;

   logic [8:0]  height_ff, width_ff;
   logic [23:0] y_step_ff;
   logic [24:0] x_step_ff;
   logic        mode_ff;

   logic advance;
   assign advance      = !rsp_ch.valid || rsp_ch.ready;
   assign req_ch.ready = advance;
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= 9'd256;
         width_ff  <= 9'd256;
         y_step_ff <= 24'd65536;
         x_step_ff <= 25'd65536;
         mode_ff   <= 1'b1;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_SRC_HEIGHT: height_ff <= csr_ch.data[8:0];
            CSR_SRC_WIDTH:  width_ff  <= csr_ch.data[8:0];
            CSR_Y_STEP:     y_step_ff <= csr_ch.data[23:0];
            CSR_X_STEP:     x_step_ff <= csr_ch.data[24:0];
            CSR_INTERLACE:  mode_ff   <= csr_ch.data[0];
            default: ;
         endcase
      end
   end

   // stage 1: scaled positions
   logic        s1_valid_ff, s1_op_ff;
   logic [1:0]  s1_plane_ff;
   logic [9:0]  s1_row_ff, s1_col_ff;
   logic [7:0]  s1_pix_ff;
   logic [33:0] s1_sy_ff;
   logic [34:0] s1_sx_ff;

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else if (advance) s1_valid_ff <= req_ch.valid;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_op_ff    <= req_ch.opcode;
         s1_plane_ff <= req_ch.plane;
         s1_row_ff   <= req_ch.row;
         s1_col_ff   <= req_ch.col;
         s1_pix_ff   <= req_ch.pixel_in;
         s1_sy_ff    <= 34'(req_ch.row) * 34'(y_step_ff);
         s1_sx_ff    <= 35'(req_ch.col) * 35'(x_step_ff);
      end
   end

   logic [17:0] fy;
   logic [18:0] fx;
   logic [15:0] ay_in, bx_in;
   logic        geom_bad, err_in, bottom_in, last_in;
   logic [7:0]  row_a, row_b, col_0, col_1;
   logic [1:0]  rd_plane;
   logic        wr_en;
   logic [8:0]  h_m2;

   always_comb begin
      fy    = s1_sy_ff[33:16];
      ay_in = s1_sy_ff[15:0];
      fx    = s1_sx_ff[34:16];
      bx_in = s1_sx_ff[15:0];
      h_m2  = height_ff - 9'd2;
      geom_bad = (height_ff < 9'd4) || (height_ff > 9'(MAX_HEIGHT)) ||
                 (width_ff < 9'd2) || (width_ff > 9'(MAX_WIDTH));
      err_in = !mode_ff || (s1_plane_ff >= 2'(PLANES)) || geom_bad ||
               (fx > 19'(width_ff - 9'd1));
      bottom_in = {fy, 1'b0} >= 19'(h_m2);
      last_in   = fx == 19'(width_ff - 9'd1);
      row_a     = bottom_in ? h_m2[7:0] : {fy[6:0], 1'b0};
      row_b     = {fy[6:0], 1'b0} + 8'd2;
      col_0     = fx[7:0];
      col_1     = fx[7:0] + 8'd1;
      rd_plane  = (s1_plane_ff >= 2'(PLANES)) ? 2'd0 : s1_plane_ff;
      wr_en     = advance && s1_valid_ff && (s1_op_ff == OP_LOAD) &&
                  (s1_plane_ff < 2'(PLANES)) && (s1_row_ff < 10'(MAX_HEIGHT)) &&
                  (s1_col_ff < 10'(MAX_WIDTH));
   end

   // stage 2: bank reads
   logic [7:0] bank_q [4];
   genvar b;
   generate
      for (b = 0; b < 4; b++) begin : g_bank
         localparam logic [1:0] BSEL = 2'(b);
         logic [7:0] mem [BANK_DEPTH];
         logic [7:0] rr, rc, q_ff;
         logic [BANK_AW-1:0] waddr, raddr;
         always_comb begin
            rr    = (row_a[1] == BSEL[1]) ? row_a : row_b;
            rc    = (col_0[0] == BSEL[0]) ? col_0 : col_1;
            raddr = {rd_plane, rr[7:2], rr[0], rc[7:1]};
            waddr = {s1_plane_ff, s1_row_ff[7:2], s1_row_ff[0], s1_col_ff[7:1]};
         end
         always_ff @(posedge clock) begin
            if (wr_en && s1_row_ff[1] == BSEL[1] && s1_col_ff[0] == BSEL[0])
               mem[waddr] <= s1_pix_ff;
            if (advance)
               q_ff <= mem[raddr];
         end
         assign bank_q[b] = q_ff;
      end
   endgenerate

   logic        s2_valid_ff, s2_err_ff, s2_bot_ff, s2_last_ff, s2_a1_ff, s2_c0_ff;
   logic [15:0] s2_ay_ff, s2_bx_ff;

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else if (advance) s2_valid_ff <= s1_valid_ff && (s1_op_ff == OP_REQUEST);
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         s2_err_ff  <= err_in;
         s2_bot_ff  <= bottom_in;
         s2_last_ff <= last_in;
         s2_a1_ff   <= row_a[1];
         s2_c0_ff   <= col_0[0];
         s2_ay_ff   <= ay_in;
         s2_bx_ff   <= bx_in;
      end
   end

   logic [7:0]  p00, p10, p01, p11;
   logic [24:0] vl_in, vr_in;
   logic [16:0] ay_inv;
   always_comb begin
      p00    = bank_q[{s2_a1_ff, s2_c0_ff}];
      p10    = bank_q[{!s2_a1_ff, s2_c0_ff}];
      p01    = bank_q[{s2_a1_ff, !s2_c0_ff}];
      p11    = bank_q[{!s2_a1_ff, !s2_c0_ff}];
      ay_inv = ONE - {1'b0, s2_ay_ff};
      vl_in  = 25'(p00) * 25'(ay_inv) + 25'(p10) * 25'(s2_ay_ff);
      vr_in  = 25'(p01) * 25'(ay_inv) + 25'(p11) * 25'(s2_ay_ff);
   end

   // stage 3: vertical blend done
   logic        s3_valid_ff, s3_err_ff, s3_bot_ff, s3_last_ff;
   logic [7:0]  s3_p_ff;
   logic [24:0] s3_vl_ff, s3_vr_ff;
   logic [15:0] s3_bx_ff;

   always_ff @(posedge clock) begin
      if (reset) s3_valid_ff <= 1'b0;
      else if (advance) s3_valid_ff <= s2_valid_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         s3_err_ff  <= s2_err_ff;
         s3_bot_ff  <= s2_bot_ff;
         s3_last_ff <= s2_last_ff;
         s3_p_ff    <= p00;
         s3_vl_ff   <= vl_in;
         s3_vr_ff   <= vr_in;
         s3_bx_ff   <= s2_bx_ff;
      end
   end

   logic [40:0] sum;
   logic [16:0] bx_inv;
   logic [7:0]  res_in;
   always_comb begin
      bx_inv = ONE - {1'b0, s3_bx_ff};
      sum    = 41'(s3_vl_ff) * 41'(bx_inv) + 41'(s3_vr_ff) * 41'(s3_bx_ff);
      if (s3_err_ff)       res_in = 8'd0;
      else if (s3_bot_ff)  res_in = s3_p_ff;
      else if (s3_last_ff) res_in = s3_vl_ff[23:16];
      else                 res_in = sum[39:32];
   end

   // stage 4: result register
   logic       rsp_valid_ff, rsp_err_ff;
   logic [7:0] rsp_pix_ff;
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (advance) rsp_valid_ff <= s3_valid_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_pix_ff <= res_in;
         rsp_err_ff <= s3_err_ff;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.out_pixel = rsp_pix_ff;
   assign rsp_ch.error     = rsp_err_ff;
endmodule
`default_nettype wire
